/* design/s7rd_pkg.sv */
// Shared types, codes and digit table for the seven-segment redraw core.
`default_nettype none
package s7rd_pkg;

  localparam int unsigned CoordW = 13;
  localparam int unsigned NumSeg = 7;

  typedef enum logic [2:0] {
    SEG_A = 3'd0,
    SEG_B = 3'd1,
    SEG_C = 3'd2,
    SEG_D = 3'd3,
    SEG_E = 3'd4,
    SEG_F = 3'd5,
    SEG_G = 3'd6
  } seg_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [1:0] {
    CFG_ROTATION  = 2'd0,
    CFG_ON_COLOR  = 2'd1,
    CFG_OFF_COLOR = 2'd2
  } cfg_idx_e;

  localparam logic [NumSeg-1:0] HorizMask = 7'b1001001;

  typedef struct packed {
    logic [9:0]               x;
    logic [9:0]               y;
    logic [9:0]               w;
    logic [9:0]               h;
    logic [7:0]               t;
    logic signed [CoordW-1:0] half;
    logic signed [CoordW-1:0] vlen;
  } geom_t;

  typedef struct packed {
    logic [NumSeg-1:0]        emit;
    logic [NumSeg-1:0]        lit;
    logic signed [CoordW-1:0] half;
    logic signed [CoordW-1:0] vlen;
  } prep_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [9:0]               w;
    logic [9:0]               h;
  } rect_t;

  function automatic logic [NumSeg-1:0] digit_mask(input logic signed [7:0] d);
    logic [NumSeg-1:0] m;
    m = '0;
    if (d >= 8'sd0 && d <= 8'sd9) begin
      case (d[3:0])
        4'd0: m = 7'h3F;
        4'd1: m = 7'h06;
        4'd2: m = 7'h5B;
        4'd3: m = 7'h4F;
        4'd4: m = 7'h66;
        4'd5: m = 7'h6D;
        4'd6: m = 7'h7D;
        4'd7: m = 7'h07;
        4'd8: m = 7'h7F;
        4'd9: m = 7'h6F;
        default: m = '0;
      endcase
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* design/s7rd_prep.sv */
// Request decode: segment selection, lit mask, split point and drop filter.
`default_nettype none
module s7rd_prep
  import s7rd_pkg::*;
(
  input  logic [9:0]        box_w_i,
  input  logic [9:0]        box_h_i,
  input  logic [7:0]        stroke_i,
  input  logic signed [7:0] new_digit_i,
  input  logic signed [7:0] old_digit_i,
  input  logic              force_all_i,
  output prep_t             prep_o
);

  logic [NumSeg-1:0]        now_m;
  logic [NumSeg-1:0]        was_m;
  logic [NumSeg-1:0]        sel;
  logic [NumSeg-1:0]        ok_m;
  logic signed [CoordW-1:0] t_s;
  logic signed [CoordW-1:0] diff;
  logic signed [CoordW-1:0] half;
  logic signed [CoordW-1:0] vlen;
  logic signed [CoordW-1:0] hlen;
  logic                     horiz_ok;
  logic                     vert_ok;

  always_comb begin
    now_m    = digit_mask(new_digit_i);
    was_m    = digit_mask(old_digit_i);
    sel      = force_all_i ? {NumSeg{1'b1}} : (now_m ^ was_m);
    t_s      = $signed({{(CoordW-8){1'b0}}, stroke_i});
    diff     = $signed({{(CoordW-10){1'b0}}, box_h_i}) - t_s;
    half     = (diff + $signed({{(CoordW-1){1'b0}}, diff[CoordW-1]})) >>> 1;
    vlen     = half - t_s;
    hlen     = $signed({{(CoordW-10){1'b0}}, box_w_i}) - (t_s <<< 1);
    horiz_ok = (stroke_i != 8'd0) && (hlen > 0);
    vert_ok  = (stroke_i != 8'd0) && (vlen > 0);
    ok_m     = (HorizMask & {NumSeg{horiz_ok}}) | (~HorizMask & {NumSeg{vert_ok}});
    prep_o.emit = sel & ok_m;
    prep_o.lit  = now_m;
    prep_o.half = half;
    prep_o.vlen = vlen;
  end

endmodule
`default_nettype wire

/* design/s7rd_rect.sv */
// Shared rectangle unit: segment geometry and quarter-turn panel mapping.
`default_nettype none
module s7rd_rect
  import s7rd_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 536,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  geom_t      geom_i,
  input  seg_e       seg_i,
  input  rot_e       rot_i,
  output rect_t      rect_o
);

  localparam logic signed [CoordW-1:0] PanW = CoordW'(PANEL_WIDTH);
  localparam logic signed [CoordW-1:0] PanH = CoordW'(PANEL_HEIGHT);

  logic signed [CoordW-1:0] x, y, w, h, t;
  logic signed [CoordW-1:0] rx, ry, rw, rh;
  logic signed [CoordW-1:0] px, py, pw, ph;

  always_comb begin
    x = $signed({{(CoordW-10){1'b0}}, geom_i.x});
    y = $signed({{(CoordW-10){1'b0}}, geom_i.y});
    w = $signed({{(CoordW-10){1'b0}}, geom_i.w});
    h = $signed({{(CoordW-10){1'b0}}, geom_i.h});
    t = $signed({{(CoordW-8){1'b0}}, geom_i.t});
    case (seg_i)
      SEG_A: begin
        rx = x + t;     ry = y;                   rw = w - (t <<< 1); rh = t;
      end
      SEG_B: begin
        rx = x + w - t; ry = y + t;               rw = t;             rh = geom_i.vlen;
      end
      SEG_C: begin
        rx = x + w - t; ry = y + geom_i.half + t; rw = t;             rh = geom_i.vlen;
      end
      SEG_D: begin
        rx = x + t;     ry = y + h - t;           rw = w - (t <<< 1); rh = t;
      end
      SEG_E: begin
        rx = x;         ry = y + geom_i.half + t; rw = t;             rh = geom_i.vlen;
      end
      SEG_F: begin
        rx = x;         ry = y + t;               rw = t;             rh = geom_i.vlen;
      end
      default: begin
        rx = x + t;     ry = y + geom_i.half;     rw = w - (t <<< 1); rh = t;
      end
    endcase
    case (rot_i)
      ROT_90: begin
        px = PanW - ry - rh; py = rx;             pw = rh; ph = rw;
      end
      ROT_180: begin
        px = PanW - rx - rw; py = PanH - ry - rh; pw = rw; ph = rh;
      end
      ROT_270: begin
        px = ry;             py = PanH - rx - rw; pw = rh; ph = rw;
      end
      default: begin
        px = rx;             py = ry;             pw = rw; ph = rh;
      end
    endcase
    rect_o.x = px;
    rect_o.y = py;
    rect_o.w = pw[9:0];
    rect_o.h = ph[9:0];
  end

endmodule
`default_nettype wire

/* design/seg7_digit_rect_redraw_core.sv */
// Top level: request capture, segment sequencer, config registers and result port.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  request  | in        | start && !busy            | box_x/y/w/h, stroke, digits, force
//  result   | out       | result_valid_o (1 cycle)  | rect_x/y/w/h, fill_color, last_rect
//  config   | in        | cfg_valid_i && cfg_ready_o| cfg_index_i, cfg_data_i
//
//  A request yields N rectangles, N between 0 and 7;
//  the single rectangle unit handles one segment per cycle.
//  Each result is registered and appears in the cycle after its segment is processed.
//  Asynchronous active-low reset clears the sequencer and sets the config registers to their defaults.
//  The result port cannot be stalled; config is always ready.
`default_nettype none
module seg7_digit_rect_redraw_core
  import s7rd_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 536,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         box_x_i,
  input  logic [9:0]         box_y_i,
  input  logic [9:0]         box_w_i,
  input  logic [9:0]         box_h_i,
  input  logic [7:0]         stroke_i,
  input  logic signed [7:0]  new_digit_i,
  input  logic signed [7:0]  old_digit_i,
  input  logic               force_all_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [11:0] rect_x_o,
  output logic signed [11:0] rect_y_o,
  output logic [9:0]         rect_w_o,
  output logic [9:0]         rect_h_o,
  output logic [15:0]        fill_color_o,
  output logic               last_rect_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [NumSeg-1:0] remain_q, remain_d;
  logic [NumSeg-1:0] lit_q;
  geom_t             geom_q;
  rot_e              rot_q;
  logic [15:0]       on_color_q;
  logic [15:0]       off_color_q;
  prep_t             prep;
  rect_t             rect;
  logic              accept;
  logic [NumSeg-1:0] pick;
  seg_e              seg;
  logic              last;

  assign busy        = (state_q == ST_EMIT);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  s7rd_prep u_prep (
    .box_w_i     (box_w_i),
    .box_h_i     (box_h_i),
    .stroke_i    (stroke_i),
    .new_digit_i (new_digit_i),
    .old_digit_i (old_digit_i),
    .force_all_i (force_all_i),
    .prep_o      (prep)
  );

  s7rd_rect #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_rect (
    .geom_i (geom_q),
    .seg_i  (seg),
    .rot_i  (rot_q),
    .rect_o (rect)
  );

  always_comb begin
    pick = '0;
    seg  = SEG_A;
    for (int i = NumSeg - 1; i >= 0; i--) begin
      if (remain_q[i]) begin
        pick = '0;
        pick[i] = 1'b1;
        seg = seg_e'(3'(i));
      end
    end
    last = ((remain_q & ~pick) == '0);
  end

  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          remain_d = prep.emit;
          if (prep.emit != '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        remain_d = remain_q & ~pick;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d  = ST_IDLE;
        remain_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      remain_q       <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      remain_q       <= remain_d;
      result_valid_o <= busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q       <= ROT_0;
      on_color_q  <= 16'hFFFF;
      off_color_q <= 16'h0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROTATION:  rot_q       <= rot_e'(cfg_data_i[1:0]);
        CFG_ON_COLOR:  on_color_q  <= cfg_data_i;
        CFG_OFF_COLOR: off_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      geom_q.x    <= box_x_i;
      geom_q.y    <= box_y_i;
      geom_q.w    <= box_w_i;
      geom_q.h    <= box_h_i;
      geom_q.t    <= stroke_i;
      geom_q.half <= prep.half;
      geom_q.vlen <= prep.vlen;
      lit_q       <= prep.lit;
    end
    if (busy) begin
      rect_x_o     <= rect.x[11:0];
      rect_y_o     <= rect.y[11:0];
      rect_w_o     <= rect.w;
      rect_h_o     <= rect.h;
      fill_color_o <= ((lit_q & pick) != '0) ? on_color_q : off_color_q;
      last_rect_o  <= last;
    end
  end

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_rect_o |=> !result_valid_o)
    else $error("result strobe right after last rectangle");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !result_valid_o)
    else $error("result strobe right after request accept");

  a_busy_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> remain_q != '0)
    else $error("sequencer busy with no segment left");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rect_w_o != 10'd0) && (rect_h_o != 10'd0))
    else $error("emitted rectangle of zero size");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && last |=> !busy)
    else $error("sequencer did not return idle after last segment");

endmodule
`default_nettype wire

/* test/redraw_rect_checker.sv */
// Checker for the seven-segment redraw core: predicts rectangles per request and compares them.
module redraw_rect_checker
  import s7rd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 536,
  parameter int PANEL_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [9:0]         box_x_i,
  input  logic [9:0]         box_y_i,
  input  logic [9:0]         box_w_i,
  input  logic [9:0]         box_h_i,
  input  logic [7:0]         stroke_i,
  input  logic signed [7:0]  new_digit_i,
  input  logic signed [7:0]  old_digit_i,
  input  logic               force_all_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               result_valid_i,
  input  logic signed [11:0] rect_x_i,
  input  logic signed [11:0] rect_y_i,
  input  logic [9:0]         rect_w_i,
  input  logic [9:0]         rect_h_i,
  input  logic [15:0]        fill_color_i,
  input  logic               last_rect_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [9:0]         w;
    logic [9:0]         h;
    logic [15:0]        color;
    logic               last;
  } fill_rect_t;

  fill_rect_t  due_rects[$];
  rot_e        rot_q;
  logic [15:0] on_color_q;
  logic [15:0] off_color_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [6:0] glyph_of(input logic signed [7:0] d);
    logic [6:0] g;
    case (d)
      8'sd0:   g = 7'h3F;
      8'sd1:   g = 7'h06;
      8'sd2:   g = 7'h5B;
      8'sd3:   g = 7'h4F;
      8'sd4:   g = 7'h66;
      8'sd5:   g = 7'h6D;
      8'sd6:   g = 7'h7D;
      8'sd7:   g = 7'h07;
      8'sd8:   g = 7'h7F;
      8'sd9:   g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  function automatic void predict_redraw(input logic [9:0] bx, input logic [9:0] by,
                                         input logic [9:0] bw, input logic [9:0] bh,
                                         input logic [7:0] st,
                                         input logic signed [7:0] nd,
                                         input logic signed [7:0] od, input logic fa);
    fill_rect_t found[7];
    int n, k, x, y, w, h, t, half, vlen, rx, ry, rw, rh, px, py, pw, ph;
    logic [6:0] lit_now, sel;
    n = 0;
    x = bx;
    y = by;
    w = bw;
    h = bh;
    t = st;
    lit_now = glyph_of(nd);
    sel = fa ? 7'h7F : (lit_now ^ glyph_of(od));
    half = (h - t) / 2;
    vlen = half - t;
    for (k = 0; k < 7; k++) begin
      if (sel[k]) begin
        case (seg_e'(k))
          SEG_A: begin rx = x + t;     ry = y;            rw = w - 2 * t; rh = t;    end
          SEG_B: begin rx = x + w - t; ry = y + t;        rw = t;         rh = vlen; end
          SEG_C: begin rx = x + w - t; ry = y + half + t; rw = t;         rh = vlen; end
          SEG_D: begin rx = x + t;     ry = y + h - t;    rw = w - 2 * t; rh = t;    end
          SEG_E: begin rx = x;         ry = y + half + t; rw = t;         rh = vlen; end
          SEG_F: begin rx = x;         ry = y + t;        rw = t;         rh = vlen; end
          default: begin rx = x + t;   ry = y + half;     rw = w - 2 * t; rh = t;    end
        endcase
        if (rw > 0 && rh > 0) begin
          case (rot_q)
            ROT_90: begin
              px = PANEL_WIDTH - ry - rh; py = rx; pw = rh; ph = rw;
            end
            ROT_180: begin
              px = PANEL_WIDTH - rx - rw; py = PANEL_HEIGHT - ry - rh; pw = rw; ph = rh;
            end
            ROT_270: begin
              px = ry; py = PANEL_HEIGHT - rx - rw; pw = rh; ph = rw;
            end
            default: begin
              px = rx; py = ry; pw = rw; ph = rh;
            end
          endcase
          found[n].x     = px[11:0];
          found[n].y     = py[11:0];
          found[n].w     = pw[9:0];
          found[n].h     = ph[9:0];
          found[n].color = lit_now[k] ? on_color_q : off_color_q;
          found[n].last  = 1'b0;
          n++;
        end
      end
    end
    for (k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      due_rects.push_back(found[k]);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fill_rect_t r;
    if (!rst_ni) begin
      rot_q       <= ROT_0;
      on_color_q  <= 16'hFFFF;
      off_color_q <= 16'h0000;
      due_rects.delete();
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        if (due_rects.size() == 0) begin
          report_mismatch("unrequested rectangle x", rect_x_i, 0);
        end else begin
          r = due_rects.pop_front();
          if (rect_x_i !== r.x) report_mismatch("rect_x", rect_x_i, r.x);
          if (rect_y_i !== r.y) report_mismatch("rect_y", rect_y_i, r.y);
          if (rect_w_i !== r.w) report_mismatch("rect_w", rect_w_i, r.w);
          if (rect_h_i !== r.h) report_mismatch("rect_h", rect_h_i, r.h);
          if (fill_color_i !== r.color) report_mismatch("fill_color", fill_color_i, r.color);
          if (last_rect_i !== r.last) report_mismatch("last_rect", last_rect_i, r.last);
        end
      end
      if (start_i && !busy_i) begin
        predict_redraw(box_x_i, box_y_i, box_w_i, box_h_i, stroke_i,
                       new_digit_i, old_digit_i, force_all_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ROTATION:  rot_q       <= rot_e'(cfg_data_i[1:0]);
          CFG_ON_COLOR:  on_color_q  <= cfg_data_i;
          CFG_OFF_COLOR: off_color_q <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o = due_rects.size();
    end
  end

endmodule

/* test/tb.sv */
// Testbench top for the seven-segment redraw core: clock, reset, requests, register writes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s7rd_pkg::*;

  localparam int PanelW = 536;
  localparam int PanelH = 240;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [9:0]         box_x_i = '0;
  logic [9:0]         box_y_i = '0;
  logic [9:0]         box_w_i = '0;
  logic [9:0]         box_h_i = '0;
  logic [7:0]         stroke_i = '0;
  logic signed [7:0]  new_digit_i = '0;
  logic signed [7:0]  old_digit_i = '0;
  logic               force_all_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic signed [11:0] rect_x_o;
  logic signed [11:0] rect_y_o;
  logic [9:0]         rect_w_o;
  logic [9:0]         rect_h_o;
  logic [15:0]        fill_color_o;
  logic               last_rect_o;
  int                 fail_count;
  int                 pending;
  logic               steady = 1'b0;

  seg7_digit_rect_redraw_core #(
    .PANEL_WIDTH (PanelW),
    .PANEL_HEIGHT(PanelH)
  ) dut (
    .clk_i, .rst_ni, .start, .busy,
    .box_x_i, .box_y_i, .box_w_i, .box_h_i, .stroke_i,
    .new_digit_i, .old_digit_i, .force_all_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .rect_x_o, .rect_y_o, .rect_w_o, .rect_h_o,
    .fill_color_o, .last_rect_o
  );

  redraw_rect_checker #(
    .PANEL_WIDTH (PanelW),
    .PANEL_HEIGHT(PanelH)
  ) checker_i (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy),
    .box_x_i, .box_y_i, .box_w_i, .box_h_i, .stroke_i,
    .new_digit_i, .old_digit_i, .force_all_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o),
    .rect_x_i(rect_x_o), .rect_y_i(rect_y_o), .rect_w_i(rect_w_o), .rect_h_i(rect_h_o),
    .fill_color_i(fill_color_o), .last_rect_i(last_rect_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_redraw(input logic [9:0] bx, input logic [9:0] by,
                             input logic [9:0] bw, input logic [9:0] bh,
                             input logic [7:0] st, input logic signed [7:0] nd,
                             input logic signed [7:0] od, input logic fa);
    if (!steady && $urandom_range(99) < 23) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    box_x_i     = bx;
    box_y_i     = by;
    box_w_i     = bw;
    box_h_i     = bh;
    stroke_i    = st;
    new_digit_i = nd;
    old_digit_i = od;
    force_all_i = fa;
    start       = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic send_random_redraw();
    logic signed [7:0] nd, od;
    if ($urandom_range(99) < 20) begin
      send_redraw(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    end else begin
      nd = 8'(($urandom_range(99) < 90) ? $urandom_range(0, 9) : $urandom);
      od = 8'(($urandom_range(99) < 85) ? $urandom_range(0, 9) : $urandom);
      if ($urandom_range(99) < 8) od = nd;
      send_redraw(10'($urandom_range(0, 700)), 10'($urandom_range(0, 700)),
                  10'($urandom_range(4, 160)), 10'($urandom_range(8, 300)),
                  8'($urandom_range(1, 24)), nd, od,
                  $urandom_range(99) < 20);
    end
  endtask

  // drop start and wait for the core to drain
  task automatic settle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_view(input rot_e rot, input logic [15:0] on_c, input logic [15:0] off_c);
    logic [15:0] junk;
    junk = 16'($urandom);
    settle();
    write_reg(CFG_ROTATION, {junk[15:2], rot});
    write_reg(CFG_ON_COLOR, on_c);
    write_reg(CFG_OFF_COLOR, off_c);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int d = 0; d < 10; d++) send_redraw(10, 20, 40, 80, 6, 8'(d), -1, 1'b0);
    send_redraw(100, 50, 60, 90, 8, 8, 8, 1'b0);
    send_redraw(100, 50, 60, 90, 8, -1, -128, 1'b1);
    send_redraw(30, 40, 50, 100, 7, 127, 3, 1'b0);
    send_redraw(30, 40, 50, 100, 7, 10, -128, 1'b1);
    send_redraw(5, 5, 50, 100, 0, 8, -1, 1'b1);
    send_redraw(1023, 1023, 1023, 1023, 255, 8, -1, 1'b1);
    send_redraw(0, 0, 0, 0, 255, 8, -1, 1'b1);
    send_redraw(1023, 1023, 1023, 1023, 1, 0, 1, 1'b0);
    send_redraw(200, 100, 10, 100, 5, 8, -1, 1'b0);
    send_redraw(60, 70, 40, 3, 8, 4, 7, 1'b1);
    send_redraw(10'h2AA, 10'h155, 10'h155, 10'h2AA, 8'hAA, 8'h55, 8'shAA, 1'b1);
    send_redraw(10'h155, 10'h2AA, 10'h2AA, 10'h155, 8'h55, 2, 6, 1'b0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_view(ROT_90, 16'h0000, 16'hFFFF);
        1:       set_view(ROT_180, 16'($urandom), 16'($urandom));
        2:       set_view(ROT_270, 16'hFFFF, 16'h0000);
        3:       set_view(ROT_0, 16'($urandom), 16'($urandom));
        default: set_view(rot_e'($urandom_range(3)), 16'($urandom), 16'($urandom));
      endcase
      steady = (p == 1);
      for (int i = 0; i < 21; i++) begin
        if (p == 2 && i == 10) settle();
        send_random_redraw();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/s7rd_pkg.sv
design/s7rd_prep.sv
design/s7rd_rect.sv
design/seg7_digit_rect_redraw_core.sv
test/redraw_rect_checker.sv
test/tb.sv
